### rtl/sca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types and constants of the scatter-add accumulator.
// ----------------------------------------------------------------------------
package sca_pkg;

    // store geometry
    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLS    = 64;
    localparam int ROW_IDX_W   = $clog2(MAX_ROWS);
    localparam int COL_W       = 6;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DATA_W      = 32;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 1'b1;
    localparam logic [8:0] ROW_COUNT_RST = 9'd256;
    localparam logic [6:0] ROW_WIDTH_RST = 7'd64;

    // item modes
    localparam logic MODE_ACCUM = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_ROW = 2'd1;
    localparam logic [1:0] STATUS_BAD_COL = 2'd2;

    // input word
    typedef struct packed {
        logic               mode;
        logic signed [15:0] row;
        logic [COL_W-1:0]   col;
        logic signed [31:0] value;
    } t_in;

    // result word
    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status;
    } t_out;

    // controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WRITE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic clr_en;
        logic load;
        logic wb;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;
    } t_stat;

endpackage

### rtl/scatter_add_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatter_add_accumulator
// Scatter-add engine over a 256 x 64 store of Q16.16 accumulators.
// ----------------------------------------------------------------------------
// After reset the block clears its 16384-entry store, one entry per cycle,
// and holds busy high while it sweeps; configuration writes are taken
// during that time. Each word then passes through accept, store read and
// write-back, set by the single store port doing a read and a write per
// word, so a new word is not accepted until the last one's write-back is
// done. The result appears on o_out with o_valid for exactly one cycle, the
// cycle after write-back, and cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module scatter_add_accumulator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sca_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sca_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           start,
    input  sca_pkg::t_in                   i_in,
    output logic                           busy,
    output sca_pkg::t_out                  o_out,
    output logic                           o_valid
);

    sca_pkg::t_cmd  w_cmd;
    sca_pkg::t_stat w_stat;

    // controller
    sca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    // datapath
    sca_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out      (o_out),
        .o_valid    (o_valid)
    );

    // result strobe follows the write-back cycle exactly
    a_valid_after_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_valid == $past(w_cmd.wb)))
        else $error("result strobe not aligned with write-back");

    // a flagged word never returns data
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out.status != sca_pkg::STATUS_OK)) |-> (o_out.result_value == '0))
        else $error("flagged word returned nonzero data");

    // no word is taken while the store is being cleared
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_en |-> busy)
        else $error("ready during clearing sweep");

    // an accepted word produces its result after the read and write-back states
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 ##1 o_valid)
        else $error("missing result for accepted word");

endmodule

### rtl/sca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sca_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_ctrl
// Controller: clearing sweep after reset, then read / write-back per word.
// ----------------------------------------------------------------------------
module sca_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  sca_pkg::t_stat i_stat,
    output sca_pkg::t_cmd  o_cmd,
    output logic           busy
);

    sca_pkg::t_state r_state;
    sca_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sca_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sca_pkg::S_CLEAR: begin
                if (i_stat.clr_last) begin
                    n_state = sca_pkg::S_IDLE;
                end
            end
            sca_pkg::S_IDLE: begin
                if (start) begin
                    n_state = sca_pkg::S_READ;
                end
            end
            sca_pkg::S_READ:  n_state = sca_pkg::S_WRITE;
            sca_pkg::S_WRITE: n_state = sca_pkg::S_IDLE;
            default:          n_state = sca_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            sca_pkg::S_CLEAR: o_cmd.clr_en = 1'b1;
            sca_pkg::S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            sca_pkg::S_READ:  o_cmd = '0;
            sca_pkg::S_WRITE: o_cmd.wb = 1'b1;
            default:          o_cmd = '0;
        endcase
    end

endmodule

### rtl/sca_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sca_dp
// Datapath: config registers, index checks, store access and saturating add.
// ----------------------------------------------------------------------------
module sca_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sca_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sca_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  sca_pkg::t_in                       i_in,
    input  sca_pkg::t_cmd                      i_cmd,
    output sca_pkg::t_stat                     o_stat,
    output sca_pkg::t_out                      o_out,
    output logic                               o_valid
);

    logic [8:0]                  r_row_count;
    logic [6:0]                  r_row_width;
    sca_pkg::t_in                r_in;
    logic [sca_pkg::ADDR_W-1:0]  r_clr_cnt;
    sca_pkg::t_out               r_out;
    logic                        r_valid;

    logic [1:0]                  w_status;
    logic                        w_row_ok;
    logic                        w_col_ok;
    logic [sca_pkg::ADDR_W-1:0]  w_addr;
    logic                        w_we;
    logic [sca_pkg::DATA_W-1:0]  w_wdata;
    logic [sca_pkg::DATA_W-1:0]  w_rdata;
    logic signed [32:0]          w_sum;
    logic signed [31:0]          w_sat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= sca_pkg::ROW_COUNT_RST;
            r_row_width <= sca_pkg::ROW_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sca_pkg::CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                sca_pkg::CFG_ROW_WIDTH: r_row_width <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // input word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in;
        end
    end

    // clearing sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    assign o_stat.clr_last = i_cmd.clr_en && (&r_clr_cnt);

    // index checks, row check wins
    assign w_row_ok = !r_in.row[15]
                   && (r_in.row[14:0] < 15'(sca_pkg::MAX_ROWS))
                   && (r_in.row[14:0] < 15'(r_row_count));
    assign w_col_ok = (7'(r_in.col) < r_row_width)
                   && (7'(r_in.col) < 7'(sca_pkg::MAX_COLS));

    always_comb begin
        priority if (!w_row_ok) begin
            w_status = sca_pkg::STATUS_BAD_ROW;
        end else if (!w_col_ok) begin
            w_status = sca_pkg::STATUS_BAD_COL;
        end else begin
            w_status = sca_pkg::STATUS_OK;
        end
    end

    // saturating add of the stored element and the update
    assign w_sum = {w_rdata[31], w_rdata} + {r_in.value[31], r_in.value};
    always_comb begin
        if (w_sum[32] != w_sum[31]) begin
            w_sat = w_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_sat = w_sum[31:0];
        end
    end

    // store port: sweep address while clearing, element address otherwise
    assign w_addr  = i_cmd.clr_en ? r_clr_cnt
                                  : {r_in.row[sca_pkg::ROW_IDX_W-1:0], r_in.col};
    assign w_we    = i_cmd.clr_en || (i_cmd.wb && (w_status == sca_pkg::STATUS_OK));
    assign w_wdata = (i_cmd.clr_en || (r_in.mode == sca_pkg::MODE_READ)) ? '0 : w_sat;

    sca_ram #(
        .WIDTH (sca_pkg::DATA_W),
        .DEPTH (sca_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            r_out.status <= w_status;
            r_out.result_value <= ((w_status == sca_pkg::STATUS_OK)
                                   && (r_in.mode == sca_pkg::MODE_READ))
                                  ? w_rdata : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.wb;
        end
    end

    assign o_out   = r_out;
    assign o_valid = r_valid;

endmodule

### sim/scatter_add_accumulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatter_add_accumulator_tb
// Self-checking bench for the scatter-add accumulator. A directed table
// covers the index checks, saturation at both ends, read-and-clear and the
// register extremes. Random phases follow under a range of row count and row
// width settings, mostly in-range words aimed at a few hot elements, with
// random idle gaps outside the burst phases. Every result is compared field by field against a
// bench-side copy of the accumulator store.
// ----------------------------------------------------------------------------
module scatter_add_accumulator_tb;

    localparam int N_PHASES        = 10;
    localparam int WORDS_PER_PHASE = 120;
    localparam int TAIL_CYCLES     = 20;

    // one line of the directed table: a register write or a word
    typedef struct {
        bit                             is_cfg;
        logic [sca_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [sca_pkg::CFG_DATA_W-1:0] reg_data;
        sca_pkg::t_in                   word;
        bit                             typed;
        sca_pkg::t_out                  exp;
    } t_dir_row;

    logic                           i_clk;
    logic                           i_rst_n    = 1'b0;
    logic                           i_cfg_we   = 1'b0;
    logic [sca_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [sca_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           start      = 1'b0;
    sca_pkg::t_in                   i_in       = '0;
    logic                           busy;
    sca_pkg::t_out                  o_out;
    logic                           o_valid;

    // bench copy of the block state
    logic signed [31:0] acc_mem [sca_pkg::STORE_DEPTH];
    int                 cfg_rows;
    int                 cfg_cols;

    sca_pkg::t_out acc_results_q [$];
    t_dir_row      dir_tab [$];
    sca_pkg::t_out mon_exp;
    int            err_count = 0;

    int phase_rows [8] = '{256, 511, 1, 0, 256, 17, 200, 3};
    int phase_cols [8] = '{64, 127, 1, 64, 0, 9, 64, 2};

    scatter_add_accumulator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .start      (start),
        .i_in       (i_in),
        .busy       (busy),
        .o_out      (o_out),
        .o_valid    (o_valid)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("scatter_add_accumulator_tb: done, errors");
        $finish;
    end

    // effective geometry after capacity clamping
    function automatic int eff_rows();
        return (cfg_rows > sca_pkg::MAX_ROWS) ? sca_pkg::MAX_ROWS : cfg_rows;
    endfunction

    function automatic int eff_cols();
        return (cfg_cols > sca_pkg::MAX_COLS) ? sca_pkg::MAX_COLS : cfg_cols;
    endfunction

    // index check, then saturating accumulate or read-and-clear
    function automatic sca_pkg::t_out apply_scatter_add(sca_pkg::t_in w);
        sca_pkg::t_out r;
        int            row_i;
        int            addr;
        longint        sum;
        row_i          = w.row;
        r.result_value = '0;
        r.status       = sca_pkg::STATUS_OK;
        if (row_i < 0 || row_i >= eff_rows()) begin
            r.status = sca_pkg::STATUS_BAD_ROW;
        end else if (int'(w.col) >= eff_cols()) begin
            r.status = sca_pkg::STATUS_BAD_COL;
        end else begin
            addr = row_i * sca_pkg::MAX_COLS + int'(w.col);
            if (w.mode == sca_pkg::MODE_READ) begin
                r.result_value = acc_mem[addr];
                acc_mem[addr]  = '0;
            end else begin
                sum = longint'(acc_mem[addr]) + longint'(w.value);
                if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                acc_mem[addr] = sum[31:0];
            end
        end
        return r;
    endfunction

    function automatic sca_pkg::t_in mk_word(logic mode, int row, int col, logic [31:0] val);
        sca_pkg::t_in w;
        w.mode  = mode;
        w.row   = row[15:0];
        w.col   = col[sca_pkg::COL_W-1:0];
        w.value = val;
        return w;
    endfunction

    function automatic void add_cfg(logic [sca_pkg::CFG_IDX_W-1:0] idx, int data);
        t_dir_row d;
        d          = '{default: '0};
        d.is_cfg   = 1'b1;
        d.reg_idx  = idx;
        d.reg_data = data[sca_pkg::CFG_DATA_W-1:0];
        dir_tab.push_back(d);
    endfunction

    function automatic void add_word(logic mode, int row, int col, logic [31:0] val,
                                     bit typed, logic [31:0] ev, logic [1:0] es);
        t_dir_row d;
        d                  = '{default: '0};
        d.word             = mk_word(mode, row, col, val);
        d.typed            = typed;
        d.exp.result_value = ev;
        d.exp.status       = es;
        dir_tab.push_back(d);
    endfunction

    // random word: mostly in range and aimed at a few hot elements
    function automatic sca_pkg::t_in rand_word();
        int          rows;
        int          cols;
        int          row_i;
        int          col_i;
        logic        mode;
        logic [31:0] val;
        rows = eff_rows();
        cols = eff_cols();
        mode = ($urandom_range(0, 99) < 30) ? sca_pkg::MODE_READ : sca_pkg::MODE_ACCUM;
        case ($urandom_range(0, 3))
            0: val = $urandom_range(0, 32'h60000) - 32'h30000;
            1: val = 32'h7FF0_0000 + $urandom_range(0, 32'h000F_FFFF);
            2: val = 32'h8000_0000 + $urandom_range(0, 32'h000F_FFFF);
            default: val = $urandom;
        endcase
        if ($urandom_range(0, 99) < 85 && rows > 0 && cols > 0) begin
            row_i = ($urandom_range(0, 3) == 0) ? $urandom_range(0, rows - 1)
                                                : $urandom_range(0, ((rows < 4) ? rows : 4) - 1);
            col_i = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cols - 1)
                                                : $urandom_range(0, ((cols < 4) ? cols : 4) - 1);
        end else if ($urandom_range(0, 1) == 0) begin
            // at and just past the configured edges
            row_i = rows + $urandom_range(0, 2) - 1;
            col_i = cols + $urandom_range(0, 2) - 1;
            mode  = 1'($urandom_range(0, 1));
        end else begin
            row_i = $urandom;
            col_i = $urandom;
            mode  = 1'($urandom_range(0, 1));
        end
        return mk_word(mode, row_i, col_i, val);
    endfunction

    // offer one word and wait for it to be taken
    task automatic send_word(input sca_pkg::t_in w, input bit typed,
                             input sca_pkg::t_out typed_exp);
        sca_pkg::t_out pred;
        start <= 1'b1;
        i_in  <= w;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pred = apply_scatter_add(w);
        acc_results_q.push_back(typed ? typed_exp : pred);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (acc_results_q.size() != 0) @(posedge i_clk);
    endtask

    // one register write, then the write port is left quiet before the task returns
    task automatic write_reg(input logic [sca_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sca_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == sca_pkg::CFG_ROW_COUNT) cfg_rows = int'(data[8:0]);
        else cfg_cols = int'(data[6:0]);
        @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (acc_results_q.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual value %h status %0d",
                         $time, o_out.result_value, o_out.status);
                err_count++;
            end else begin
                mon_exp = acc_results_q.pop_front();
                if (o_out.result_value !== mon_exp.result_value) begin
                    $display("%0t: result_value mismatch: expected %h, actual %h",
                             $time, mon_exp.result_value, o_out.result_value);
                    err_count++;
                end
                if (o_out.status !== mon_exp.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, mon_exp.status, o_out.status);
                    err_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        int rc;
        int rw;
        bit burst;
        foreach (acc_mem[k]) acc_mem[k] = '0;
        cfg_rows = int'(sca_pkg::ROW_COUNT_RST);
        cfg_cols = int'(sca_pkg::ROW_WIDTH_RST);

        // directed table
        add_word(sca_pkg::MODE_READ, 0, 0, 32'h0, 1, 32'h0, sca_pkg::STATUS_OK);
        add_word(sca_pkg::MODE_ACCUM, 0, 0, 32'h7FFF_FFFF, 1, 32'h0, sca_pkg::STATUS_OK);
        add_word(sca_pkg::MODE_ACCUM, 0, 0, 32'h1, 1, 32'h0, sca_pkg::STATUS_OK);
        add_word(sca_pkg::MODE_READ, 0, 0, 32'h1234_5678, 1, 32'h7FFF_FFFF,
                 sca_pkg::STATUS_OK);
        add_word(sca_pkg::MODE_READ, 0, 0, 32'h0, 1, 32'h0, sca_pkg::STATUS_OK);
        add_word(sca_pkg::MODE_ACCUM, 255, 63, 32'h8000_0000, 1, 32'h0, sca_pkg::STATUS_OK);
        add_word(sca_pkg::MODE_ACCUM, 255, 63, 32'hFFFF_FFFF, 1, 32'h0, sca_pkg::STATUS_OK);
        add_word(sca_pkg::MODE_READ, 255, 63, 32'h0, 1, 32'h8000_0000, sca_pkg::STATUS_OK);
        add_word(sca_pkg::MODE_ACCUM, -1, 0, 32'h0001_0000, 1, 32'h0,
                 sca_pkg::STATUS_BAD_ROW);
        add_word(sca_pkg::MODE_READ, -32768, 0, 32'h0, 1, 32'h0, sca_pkg::STATUS_BAD_ROW);
        add_word(sca_pkg::MODE_ACCUM, 256, 0, 32'h0001_0000, 1, 32'h0,
                 sca_pkg::STATUS_BAD_ROW);
        add_word(sca_pkg::MODE_ACCUM, 32767, 63, 32'h7FFF_FFFF, 1, 32'h0,
                 sca_pkg::STATUS_BAD_ROW);
        add_word(sca_pkg::MODE_ACCUM, 1, 5, 32'h0001_8000, 0, 32'h0, sca_pkg::STATUS_OK);
        add_word(sca_pkg::MODE_ACCUM, 1, 5, 32'hFFFF_4000, 0, 32'h0, sca_pkg::STATUS_OK);
        add_word(sca_pkg::MODE_READ, 1, 5, 32'h0, 0, 32'h0, sca_pkg::STATUS_OK);
        // zero row width, then both indices bad
        add_cfg(sca_pkg::CFG_ROW_WIDTH, 0);
        add_word(sca_pkg::MODE_ACCUM, 0, 0, 32'h0001_0000, 1, 32'h0,
                 sca_pkg::STATUS_BAD_COL);
        add_word(sca_pkg::MODE_READ, 300, 0, 32'h0, 1, 32'h0, sca_pkg::STATUS_BAD_ROW);
        // both registers above capacity
        add_cfg(sca_pkg::CFG_ROW_COUNT, 511);
        add_cfg(sca_pkg::CFG_ROW_WIDTH, 127);
        add_word(sca_pkg::MODE_READ, 256, 63, 32'h0, 1, 32'h0, sca_pkg::STATUS_BAD_ROW);
        add_word(sca_pkg::MODE_ACCUM, 255, 63, 32'h0000_002A, 0, 32'h0, sca_pkg::STATUS_OK);
        add_word(sca_pkg::MODE_READ, 255, 63, 32'h0, 0, 32'h0, sca_pkg::STATUS_OK);
        // zero row count
        add_cfg(sca_pkg::CFG_ROW_COUNT, 0);
        add_word(sca_pkg::MODE_READ, 0, 0, 32'h0, 1, 32'h0, sca_pkg::STATUS_BAD_ROW);
        // single element store
        add_cfg(sca_pkg::CFG_ROW_COUNT, 1);
        add_cfg(sca_pkg::CFG_ROW_WIDTH, 1);
        add_word(sca_pkg::MODE_ACCUM, 0, 0, 32'h5, 0, 32'h0, sca_pkg::STATUS_OK);
        add_word(sca_pkg::MODE_ACCUM, 0, 1, 32'h5, 1, 32'h0, sca_pkg::STATUS_BAD_COL);
        add_word(sca_pkg::MODE_ACCUM, 1, 0, 32'h5, 1, 32'h0, sca_pkg::STATUS_BAD_ROW);
        add_word(sca_pkg::MODE_READ, 0, 0, 32'h0, 0, 32'h0, sca_pkg::STATUS_OK);
        add_word(sca_pkg::MODE_READ, 0, 63, 32'h0, 1, 32'h0, sca_pkg::STATUS_BAD_COL);

        // reset
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table
        foreach (dir_tab[n]) begin
            if (dir_tab[n].is_cfg) begin
                drain();
                write_reg(dir_tab[n].reg_idx, dir_tab[n].reg_data);
            end else begin
                send_word(dir_tab[n].word, dir_tab[n].typed, dir_tab[n].exp);
                pause($urandom_range(0, 18));
            end
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            if (ph < 8) begin
                rc = phase_rows[ph];
                rw = phase_cols[ph];
            end else begin
                rc = $urandom_range(0, 511);
                rw = $urandom_range(0, 127);
            end
            write_reg(sca_pkg::CFG_ROW_COUNT, rc[sca_pkg::CFG_DATA_W-1:0]);
            write_reg(sca_pkg::CFG_ROW_WIDTH, rw[sca_pkg::CFG_DATA_W-1:0]);
            burst = (ph % 3 == 1);
            for (int i = 0; i < WORDS_PER_PHASE; i++) begin
                send_word(rand_word(), 1'b0, '0);
                pause(burst ? 0 : $urandom_range(0, 18));
            end
        end

        // wind down
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("scatter_add_accumulator_tb: done, clean");
        end else begin
            $display("scatter_add_accumulator_tb: done, errors");
        end
        $finish;
    end

endmodule
